// ===== src/voronoi_nearest_site_labeler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// voronoi nearest site labeler assertion macros
// property wrappers on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef VORONOI_NEAREST_SITE_LABELER_UNIT_ASSERT_SVH
`define VORONOI_NEAREST_SITE_LABELER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define VNSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vnsl assertion failed");
// next-cycle implication
`define VNSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vnsl assertion failed");
`else
`define VNSL_ASSERT_NOW(label, ante, cons)
`define VNSL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/vnsl_pkg.sv =====
// ----------------------------------------------------------------------------
// vnsl_pkg
// shared types and constants of the nearest site labeler
// ----------------------------------------------------------------------------
package vnsl_pkg;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2
    } vnsl_op_t;

    // fixed result field widths
    localparam int IDX_W  = 6;
    localparam int DIST_W = 19;
    localparam int CH_W   = 8;

    // marker color
    localparam logic [CH_W-1:0] MARK_R = 8'h07;
    localparam logic [CH_W-1:0] MARK_G = 8'hff;
    localparam logic [CH_W-1:0] MARK_B = 8'h07;

    // controller to datapath commands
    typedef struct packed {
        logic load_site;
        logic clear_sites;
        logic cap_query;
        logic issue;
        logic col_rd;
        logic put_result;
    } vnsl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_busy;
    } vnsl_stat_t;

endpackage

// ===== src/vnsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// vnsl_ctrl
// sequencer: decodes input words and steps a query through scan and output
// ----------------------------------------------------------------------------
module vnsl_ctrl
    import vnsl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic       m_ready,
    input  vnsl_stat_t stat,
    output vnsl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_COLOR = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    vnsl_op_t op;
    logic     accept;
    logic     out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign op       = vnsl_op_t'(s_op);
    assign out_free = !stat.out_busy || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_LOAD:  cmd.load_site   = 1'b1;
                        OP_CLEAR: cmd.clear_sites = 1'b1;
                        OP_QUERY: begin
                            cmd.cap_query = 1'b1;
                            state_next    = stat.count_zero ? ST_WRITE : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_COLOR;
                end
            end
            ST_COLOR: begin
                cmd.col_rd = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    cmd.put_result = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/vnsl_datapath.sv =====
// ----------------------------------------------------------------------------
// vnsl_datapath
// site memories, distance pipeline, nearest tracking and result register
// ----------------------------------------------------------------------------
`include "voronoi_nearest_site_labeler_unit_assert.svh"

module vnsl_datapath
    import vnsl_pkg::*;
#(
    parameter int MAX_SITES  = 64,
    parameter int COORD_BITS = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vnsl_cmd_t             cmd,
    output vnsl_stat_t            stat,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [CH_W-1:0]       s_red_in,
    input  logic [CH_W-1:0]       s_green_in,
    input  logic [CH_W-1:0]       s_blue_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [IDX_W-1:0]      m_site_index,
    output logic [DIST_W-1:0]     m_dist_sq,
    output logic                  m_on_marker,
    output logic [CH_W-1:0]       m_red,
    output logic [CH_W-1:0]       m_green,
    output logic [CH_W-1:0]       m_blue
);

    localparam int AW  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CW  = $clog2(MAX_SITES + 1);
    localparam int SW  = 2 * COORD_BITS;
    localparam int DW  = SW + 1;
    localparam int COL = 3 * CH_W;

    // site storage
    logic [2*COORD_BITS-1:0] xy_mem  [MAX_SITES];
    logic [COL-1:0]          col_mem [MAX_SITES];

    logic [CW-1:0]         site_count_reg;
    logic                  table_full;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  q_empty_reg;
    logic [AW-1:0]         scan_idx_reg;

    // pipeline registers
    logic                  p1_v_reg, p2_v_reg, p3_v_reg;
    logic [AW-1:0]         p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [COORD_BITS-1:0] rx_reg, ry_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [SW-1:0]         sqx_reg, sqy_reg;
    logic                  mk3_reg;
    logic [COORD_BITS-1:0] dx_next, dy_next;
    logic                  mk2;
    logic [DW-1:0]         dist_sum;

    // running best
    logic [DW-1:0]  best_d_reg;
    logic [AW-1:0]  best_idx_reg;
    logic           marker_reg;
    logic [COL-1:0] col_q_reg;

    // result register
    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [IDX_W-1:0]      m_site_index_reg;
    logic [DIST_W-1:0]     m_dist_sq_reg;
    logic                  m_on_marker_reg;
    logic [CH_W-1:0]       m_red_reg, m_green_reg, m_blue_reg;

    assign table_full = (site_count_reg >= CW'(MAX_SITES));

    // status
    assign stat.count_zero = (site_count_reg == '0);
    assign stat.scan_last  = ((CW'(scan_idx_reg) + CW'(1)) == site_count_reg);
    assign stat.pipe_busy  = p1_v_reg || p2_v_reg || p3_v_reg;
    assign stat.out_busy   = m_valid_reg;

    // site count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_count_reg <= '0;
        end else if (cmd.clear_sites) begin
            site_count_reg <= '0;
        end else if (cmd.load_site && !table_full) begin
            site_count_reg <= site_count_reg + CW'(1);
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        if (cmd.load_site && !table_full) begin
            xy_mem[site_count_reg[AW-1:0]]  <= {s_pos_x, s_pos_y};
            col_mem[site_count_reg[AW-1:0]] <= {s_red_in, s_green_in, s_blue_in};
        end
    end

    // query capture and scan index
    always_ff @(posedge aclk) begin
        if (cmd.cap_query) begin
            px_reg       <= s_pos_x;
            py_reg       <= s_pos_y;
            q_empty_reg  <= (site_count_reg == '0);
            scan_idx_reg <= '0;
        end else if (cmd.issue) begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= cmd.issue;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    // stage 1: coordinate read
    always_ff @(posedge aclk) begin
        {rx_reg, ry_reg} <= xy_mem[scan_idx_reg];
        p1_idx_reg       <= scan_idx_reg;
    end

    // stage 2: absolute differences
    assign dx_next = (px_reg >= rx_reg) ? (px_reg - rx_reg) : (rx_reg - px_reg);
    assign dy_next = (py_reg >= ry_reg) ? (py_reg - ry_reg) : (ry_reg - py_reg);

    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        p2_idx_reg <= p1_idx_reg;
    end

    // stage 3: squares and marker test
    assign mk2 = (dx_reg <= COORD_BITS'(1)) && (dy_reg <= COORD_BITS'(1));

    always_ff @(posedge aclk) begin
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
        mk3_reg    <= mk2;
        p3_idx_reg <= p2_idx_reg;
    end

    // stage 4: sum and keep the nearest, lowest index on ties
    assign dist_sum = DW'(sqx_reg) + DW'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (cmd.cap_query) begin
            marker_reg   <= 1'b0;
            best_d_reg   <= '0;
            best_idx_reg <= '0;
        end else if (p3_v_reg) begin
            if (p3_idx_reg == '0 || dist_sum < best_d_reg) begin
                best_d_reg   <= dist_sum;
                best_idx_reg <= p3_idx_reg;
            end
            if (mk3_reg) begin
                marker_reg <= 1'b1;
            end
        end
    end

    // color read of the winner
    always_ff @(posedge aclk) begin
        if (cmd.col_rd) begin
            col_q_reg <= col_mem[best_idx_reg];
        end
    end

    // result word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.put_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        if (cmd.put_result) begin
            if (q_empty_reg) begin
                m_found_reg      <= 1'b0;
                m_site_index_reg <= '0;
                m_dist_sq_reg    <= '0;
                m_on_marker_reg  <= 1'b0;
                m_red_reg        <= '0;
                m_green_reg      <= '0;
                m_blue_reg       <= '0;
            end else begin
                m_found_reg      <= 1'b1;
                m_site_index_reg <= IDX_W'(best_idx_reg);
                m_dist_sq_reg    <= DIST_W'(best_d_reg);
                m_on_marker_reg  <= marker_reg;
                if (marker_reg) begin
                    m_red_reg   <= MARK_R;
                    m_green_reg <= MARK_G;
                    m_blue_reg  <= MARK_B;
                end else begin
                    m_red_reg   <= col_q_reg[3*CH_W-1:2*CH_W];
                    m_green_reg <= col_q_reg[2*CH_W-1:CH_W];
                    m_blue_reg  <= col_q_reg[CH_W-1:0];
                end
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_site_index = m_site_index_reg;
    assign m_dist_sq    = m_dist_sq_reg;
    assign m_on_marker  = m_on_marker_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;

    // checks
    `VNSL_ASSERT_NOW(a_count_bound, 1'b1, site_count_reg <= CW'(MAX_SITES))
    `VNSL_ASSERT_NEXT(a_full_load_ignored, cmd.load_site && table_full, $stable(site_count_reg))
    `VNSL_ASSERT_NOW(a_issue_in_table, cmd.issue, CW'(scan_idx_reg) < site_count_reg)
    `VNSL_ASSERT_NOW(a_no_overwrite, cmd.put_result, !m_valid_reg || m_ready)

endmodule

// ===== src/voronoi_nearest_site_labeler_unit.sv =====
// ----------------------------------------------------------------------------
// voronoi_nearest_site_labeler_unit: brute force nearest site labeler
// load and clear words complete in the idle state; a query scans the stored
// sites one per cycle through the shared distance pipeline, drains it, reads
// the winner's color and writes the result; an empty table skips the scan
// one word is in work at a time; the result register frees the input side
// synchronous active-low reset empties the table and drops any pending result
// ----------------------------------------------------------------------------
module voronoi_nearest_site_labeler_unit
    import vnsl_pkg::*;
#(
    parameter int MAX_SITES  = 64,
    parameter int COORD_BITS = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [CH_W-1:0]       s_red_in,
    input  logic [CH_W-1:0]       s_green_in,
    input  logic [CH_W-1:0]       s_blue_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [IDX_W-1:0]      m_site_index,
    output logic [DIST_W-1:0]     m_dist_sq,
    output logic                  m_on_marker,
    output logic [CH_W-1:0]       m_red,
    output logic [CH_W-1:0]       m_green,
    output logic [CH_W-1:0]       m_blue
);

    vnsl_cmd_t  cmd;
    vnsl_stat_t stat;

    // sequencer
    vnsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage and distance datapath
    vnsl_datapath #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_site_index (m_site_index),
        .m_dist_sq    (m_dist_sq),
        .m_on_marker  (m_on_marker),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

endmodule
